/* src/kwrm_pkg.sv */
// shared types, codes and widths for the k-way record merge
package kwrm_pkg;

   // default sizing
   localparam int MAX_WAYS_DEF  = 16;
   localparam int KEY_BYTES_DEF = 8;

   // port field widths
   localparam int TYPE_W     = 2;
   localparam int LANE_W     = 4;
   localparam int KEY_PORT_W = 64;
   localparam int TAG_W      = 32;
   localparam int CSR_W      = 5;

   // fan-in after reset
   localparam logic [CSR_W-1:0] CSR_RESET = 5'd2;

   // depth of the small beat queues, a power of two
   localparam int QUEUE_DEPTH = 2;

   // request codes on req_type
   typedef enum logic [TYPE_W-1:0] {
      REQ_RECORD  = 2'd0,
      REQ_EXHAUST = 2'd1,
      REQ_START   = 2'd2
   } req_code_type;

   // classified command handed from front to back
   typedef enum logic [1:0] {
      OP_NONE,
      OP_FILL,
      OP_CLOSE,
      OP_START
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type              op;
      logic [LANE_W-1:0]       lane;
   } cmd_ctl_type;

   // result kinds
   typedef enum logic {
      RK_RECORD = 1'b0,
      RK_DONE   = 1'b1
   } result_kind_type;

   // back-end sequencer
   typedef enum logic [1:0] {
      ST_APPLY,
      ST_WAIT,
      ST_EMIT
   } back_state_type;

endpackage

/* src/kwrm_front.sv */
// front end: accepts request beats, classifies them and queues commands
module kwrm_front #(
   parameter int MAX_WAYS  = kwrm_pkg::MAX_WAYS_DEF,
   parameter int KEY_BYTES = kwrm_pkg::KEY_BYTES_DEF,
   localparam int KEY_W    = KEY_BYTES * 8,
   localparam int FAN_W    = $clog2(MAX_WAYS + 1)
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_push,
   output logic                               req_full,
   input  logic [kwrm_pkg::TYPE_W-1:0]        req_type,
   input  logic [kwrm_pkg::LANE_W-1:0]        req_lane,
   input  logic [kwrm_pkg::KEY_PORT_W-1:0]    req_name_key,
   input  logic [kwrm_pkg::KEY_PORT_W-1:0]    req_surname_key,
   input  logic [kwrm_pkg::TAG_W-1:0]         req_record_tag,
   input  logic [FAN_W-1:0]                   fan_in,
   output kwrm_pkg::cmd_ctl_type              cmd_ctl,
   output logic [KEY_W-1:0]                   cmd_name,
   output logic [KEY_W-1:0]                   cmd_surname,
   output logic [kwrm_pkg::TAG_W-1:0]         cmd_tag,
   output logic                               cmd_avail,
   input  logic                               cmd_pop
);
   import kwrm_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_ctl_type         q_ctl_ff     [QUEUE_DEPTH];
   logic [KEY_W-1:0]    q_name_ff    [QUEUE_DEPTH];
   logic [KEY_W-1:0]    q_surname_ff [QUEUE_DEPTH];
   logic [TAG_W-1:0]    q_tag_ff     [QUEUE_DEPTH];

   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;

   logic                accept;
   logic                do_pop;
   logic                lane_ok;
   cmd_ctl_type         ctl_new;

   // handshake
   assign req_full  = (cnt_ff == CNT_W'(QUEUE_DEPTH));
   assign cmd_avail = (cnt_ff != '0);
   assign accept    = req_push && !req_full;
   assign do_pop    = cmd_pop && cmd_avail;

   // classify: lanes outside the fan-in and unknown codes turn into no-ops
   always_comb begin
      lane_ok      = (int'(req_lane) < int'(fan_in)) && (int'(req_lane) < MAX_WAYS);
      ctl_new.lane = req_lane;
      case (req_type)
         REQ_RECORD:  ctl_new.op = lane_ok ? OP_FILL : OP_NONE;
         REQ_EXHAUST: ctl_new.op = lane_ok ? OP_CLOSE : OP_NONE;
         REQ_START:   ctl_new.op = OP_START;
         default:     ctl_new.op = OP_NONE;
      endcase
   end

   // queue pointers and fill count
   always_comb begin
      wr_ptr_in = accept ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (accept && !do_pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (!accept && do_pop) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // queue storage, keys cut to the configured key width
   always_ff @(posedge clock) begin
      if (accept) begin
         q_ctl_ff[wr_ptr_ff]     <= ctl_new;
         q_name_ff[wr_ptr_ff]    <= req_name_key[KEY_W-1:0];
         q_surname_ff[wr_ptr_ff] <= req_surname_key[KEY_W-1:0];
         q_tag_ff[wr_ptr_ff]     <= req_record_tag;
      end
   end

   // head of queue
   assign cmd_ctl     = q_ctl_ff[rd_ptr_ff];
   assign cmd_name    = q_name_ff[rd_ptr_ff];
   assign cmd_surname = q_surname_ff[rd_ptr_ff];
   assign cmd_tag     = q_tag_ff[rd_ptr_ff];

   // a beat taken without a pop grows the queue by exactly one
   a_fill_step: assert property (@(posedge clock) disable iff (reset)
      (accept && !do_pop) |=> (cnt_ff == $past(cnt_ff) + CNT_W'(1)))
      else $error("command queue count did not step on accept");

endmodule

/* src/kwrm_min_tree.sv */
// registered minimum tree over the lane heads, with a register at each tree level
module kwrm_min_tree #(
   parameter int MAX_WAYS  = kwrm_pkg::MAX_WAYS_DEF,
   parameter int KEY_BYTES = kwrm_pkg::KEY_BYTES_DEF,
   localparam int KEY_W    = KEY_BYTES * 8,
   localparam int IDX_W    = $clog2(MAX_WAYS)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [MAX_WAYS-1:0]         leaf_valid,
   input  logic [KEY_W-1:0]            leaf_name    [MAX_WAYS],
   input  logic [KEY_W-1:0]            leaf_surname [MAX_WAYS],
   input  logic [kwrm_pkg::TAG_W-1:0]  leaf_tag     [MAX_WAYS],
   output logic                        root_valid,
   output logic [IDX_W-1:0]            root_lane,
   output logic [KEY_W-1:0]            root_name,
   output logic [KEY_W-1:0]            root_surname,
   output logic [kwrm_pkg::TAG_W-1:0]  root_tag
);
   import kwrm_pkg::*;

   localparam int LEVELS = IDX_W;
   localparam int LEAVES = 1 << LEVELS;
   localparam int NODES  = LEAVES - 1;

   // padded leaves
   logic                pad_valid   [LEAVES];
   logic [IDX_W-1:0]    pad_lane    [LEAVES];
   logic [KEY_W-1:0]    pad_name    [LEAVES];
   logic [KEY_W-1:0]    pad_surname [LEAVES];
   logic [TAG_W-1:0]    pad_tag     [LEAVES];

   // inner nodes, heap order, node 0 is the root
   logic                node_valid_ff   [NODES];
   logic [IDX_W-1:0]    node_lane_ff    [NODES];
   logic [KEY_W-1:0]    node_name_ff    [NODES];
   logic [KEY_W-1:0]    node_surname_ff [NODES];
   logic [TAG_W-1:0]    node_tag_ff     [NODES];

   genvar j, n;

   // leaves past the lane count never win
   generate
      for (j = 0; j < LEAVES; j++) begin : g_pad
         assign pad_lane[j] = IDX_W'(j);
         if (j < MAX_WAYS) begin : g_real
            assign pad_valid[j]   = leaf_valid[j];
            assign pad_name[j]    = leaf_name[j];
            assign pad_surname[j] = leaf_surname[j];
            assign pad_tag[j]     = leaf_tag[j];
         end else begin : g_empty
            assign pad_valid[j]   = 1'b0;
            assign pad_name[j]    = '0;
            assign pad_surname[j] = '0;
            assign pad_tag[j]     = '0;
         end
      end
   endgenerate

   // each node keeps the smaller child, the left (lower lane) on a tie
   generate
      for (n = 0; n < NODES; n++) begin : g_node
         localparam int LC = 2 * n + 1;
         localparam int RC = 2 * n + 2;

         logic             l_valid, r_valid, right_wins;
         logic [IDX_W-1:0] l_lane, r_lane;
         logic [KEY_W-1:0] l_name, r_name, l_sur, r_sur;
         logic [TAG_W-1:0] l_tag, r_tag;

         if (LC >= NODES) begin : g_from_leaf
            assign l_valid = pad_valid[LC-NODES];
            assign l_lane  = pad_lane[LC-NODES];
            assign l_name  = pad_name[LC-NODES];
            assign l_sur   = pad_surname[LC-NODES];
            assign l_tag   = pad_tag[LC-NODES];
            assign r_valid = pad_valid[RC-NODES];
            assign r_lane  = pad_lane[RC-NODES];
            assign r_name  = pad_name[RC-NODES];
            assign r_sur   = pad_surname[RC-NODES];
            assign r_tag   = pad_tag[RC-NODES];
         end else begin : g_from_node
            assign l_valid = node_valid_ff[LC];
            assign l_lane  = node_lane_ff[LC];
            assign l_name  = node_name_ff[LC];
            assign l_sur   = node_surname_ff[LC];
            assign l_tag   = node_tag_ff[LC];
            assign r_valid = node_valid_ff[RC];
            assign r_lane  = node_lane_ff[RC];
            assign r_name  = node_name_ff[RC];
            assign r_sur   = node_surname_ff[RC];
            assign r_tag   = node_tag_ff[RC];
         end

         assign right_wins = r_valid && (!l_valid || (l_name > r_name) ||
                             ((l_name == r_name) && (l_sur > r_sur)));

         always_ff @(posedge clock) begin
            if (reset) begin
               node_valid_ff[n] <= 1'b0;
            end else begin
               node_valid_ff[n] <= l_valid || r_valid;
            end
         end

         always_ff @(posedge clock) begin
            node_lane_ff[n]    <= right_wins ? r_lane : l_lane;
            node_name_ff[n]    <= right_wins ? r_name : l_name;
            node_surname_ff[n] <= right_wins ? r_sur  : l_sur;
            node_tag_ff[n]     <= right_wins ? r_tag  : l_tag;
         end
      end
   endgenerate

   assign root_valid   = node_valid_ff[0];
   assign root_lane    = node_lane_ff[0];
   assign root_name    = node_name_ff[0];
   assign root_surname = node_surname_ff[0];
   assign root_tag     = node_tag_ff[0];

   // a valid root needs a valid leaf that has passed through every registered tree level
   a_root_from_leaf: assert property (@(posedge clock) disable iff (reset)
      root_valid |-> $past(|leaf_valid, LEVELS))
      else $error("min tree root valid without any valid leaf");

endmodule

/* src/kwrm_back.sv */
// back end: lane heads and marks, merge sequencer and result queue
module kwrm_back #(
   parameter int MAX_WAYS  = kwrm_pkg::MAX_WAYS_DEF,
   parameter int KEY_BYTES = kwrm_pkg::KEY_BYTES_DEF,
   localparam int KEY_W    = KEY_BYTES * 8,
   localparam int FAN_W    = $clog2(MAX_WAYS + 1)
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [FAN_W-1:0]                   fan_in,
   input  kwrm_pkg::cmd_ctl_type              cmd_ctl,
   input  logic [KEY_W-1:0]                   cmd_name,
   input  logic [KEY_W-1:0]                   cmd_surname,
   input  logic [kwrm_pkg::TAG_W-1:0]         cmd_tag,
   input  logic                               cmd_avail,
   output logic                               cmd_pop,
   output logic                               rsp_empty,
   input  logic                               rsp_pop,
   output logic                               rsp_result_kind,
   output logic [kwrm_pkg::LANE_W-1:0]        rsp_from_lane,
   output logic [kwrm_pkg::KEY_PORT_W-1:0]    rsp_out_name,
   output logic [kwrm_pkg::KEY_PORT_W-1:0]    rsp_out_surname,
   output logic [kwrm_pkg::TAG_W-1:0]         rsp_out_tag
);
   import kwrm_pkg::*;

   localparam int IDX_W  = $clog2(MAX_WAYS);
   localparam int LEVELS = IDX_W;
   localparam int WAIT_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);

   // lane heads, written only on a record beat
   logic [KEY_W-1:0]     head_name_ff    [MAX_WAYS];
   logic [KEY_W-1:0]     head_surname_ff [MAX_WAYS];
   logic [TAG_W-1:0]     head_tag_ff     [MAX_WAYS];

   logic [MAX_WAYS-1:0]  valid_ff, valid_in;
   logic [MAX_WAYS-1:0]  waiting_ff, waiting_in;
   logic [MAX_WAYS-1:0]  fan_mask;
   logic                 group_ff, group_in;
   back_state_type       state_ff, state_in;
   logic [WAIT_W-1:0]    wait_cnt_ff, wait_cnt_in;

   logic [IDX_W-1:0]     lane_idx;
   logic                 hit;
   logic                 head_we;
   logic                 need_emit;

   logic                 root_valid;
   logic [IDX_W-1:0]     root_lane;
   logic [KEY_W-1:0]     root_name;
   logic [KEY_W-1:0]     root_surname;
   logic [TAG_W-1:0]     root_tag;

   // result queue
   logic                  oq_kind_ff    [QUEUE_DEPTH];
   logic [LANE_W-1:0]     oq_lane_ff    [QUEUE_DEPTH];
   logic [KEY_PORT_W-1:0] oq_name_ff    [QUEUE_DEPTH];
   logic [KEY_PORT_W-1:0] oq_surname_ff [QUEUE_DEPTH];
   logic [TAG_W-1:0]      oq_tag_ff     [QUEUE_DEPTH];
   logic [PTR_W-1:0]      owr_ptr_ff, owr_ptr_in;
   logic [PTR_W-1:0]      ord_ptr_ff, ord_ptr_in;
   logic [CNT_W-1:0]      ocnt_ff, ocnt_in;
   logic                  out_full;
   logic                  out_push;
   logic                  out_pop;
   result_kind_type       res_kind;
   logic [LANE_W-1:0]     res_lane;
   logic [KEY_PORT_W-1:0] res_name;
   logic [KEY_PORT_W-1:0] res_surname;
   logic [TAG_W-1:0]      res_tag;

   // lanes below the fan-in
   always_comb begin
      for (int i = 0; i < MAX_WAYS; i++) begin
         fan_mask[i] = (i < int'(fan_in));
      end
   end

   assign lane_idx = IDX_W'(cmd_ctl.lane);
   assign hit      = group_ff && waiting_ff[lane_idx];

   // minimum search over the heads in use
   kwrm_min_tree #(
      .MAX_WAYS  (MAX_WAYS),
      .KEY_BYTES (KEY_BYTES)
   ) u_min_tree (
      .clock        (clock),
      .reset        (reset),
      .leaf_valid   (valid_ff & fan_mask),
      .leaf_name    (head_name_ff),
      .leaf_surname (head_surname_ff),
      .leaf_tag     (head_tag_ff),
      .root_valid   (root_valid),
      .root_lane    (root_lane),
      .root_name    (root_name),
      .root_surname (root_surname),
      .root_tag     (root_tag)
   );

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_APPLY: begin
            if (cmd_avail && need_emit) begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (wait_cnt_ff == '0) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!out_full) begin
               state_in = ST_APPLY;
            end
         end
         default: state_in = ST_APPLY;
      endcase
   end

   // sequencer actions and lane mark updates
   always_comb begin
      cmd_pop     = 1'b0;
      out_push    = 1'b0;
      head_we     = 1'b0;
      valid_in    = valid_ff;
      waiting_in  = waiting_ff;
      group_in    = group_ff;
      wait_cnt_in = wait_cnt_ff;
      case (state_ff)
         ST_APPLY: begin
            wait_cnt_in = WAIT_W'(LEVELS - 1);
            if (cmd_avail) begin
               cmd_pop = 1'b1;
               case (cmd_ctl.op)
                  OP_START: begin
                     valid_in   = '0;
                     waiting_in = fan_mask;
                     group_in   = 1'b1;
                  end
                  OP_FILL: begin
                     if (hit) begin
                        head_we              = 1'b1;
                        valid_in[lane_idx]   = 1'b1;
                        waiting_in[lane_idx] = 1'b0;
                     end
                  end
                  OP_CLOSE: begin
                     if (hit) begin
                        valid_in[lane_idx]   = 1'b0;
                        waiting_in[lane_idx] = 1'b0;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_WAIT: begin
            if (wait_cnt_ff != '0) begin
               wait_cnt_in = wait_cnt_ff - WAIT_W'(1);
            end
         end
         ST_EMIT: begin
            if (!out_full) begin
               out_push = 1'b1;
               if (root_valid) begin
                  valid_in[root_lane]   = 1'b0;
                  waiting_in[root_lane] = 1'b1;
               end else begin
                  group_in = 1'b0;
               end
            end
         end
         default: ;
      endcase
      need_emit = group_in && ((waiting_in & fan_mask) == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_APPLY;
         valid_ff    <= '0;
         waiting_ff  <= '0;
         group_ff    <= 1'b0;
         wait_cnt_ff <= '0;
      end else begin
         state_ff    <= state_in;
         valid_ff    <= valid_in;
         waiting_ff  <= waiting_in;
         group_ff    <= group_in;
         wait_cnt_ff <= wait_cnt_in;
      end
   end

   // head storage
   always_ff @(posedge clock) begin
      if (head_we) begin
         head_name_ff[lane_idx]    <= cmd_name;
         head_surname_ff[lane_idx] <= cmd_surname;
         head_tag_ff[lane_idx]     <= cmd_tag;
      end
   end

   // result beat: smallest head, or group done with zero payload
   always_comb begin
      res_kind    = root_valid ? RK_RECORD : RK_DONE;
      res_lane    = root_valid ? LANE_W'(root_lane) : '0;
      res_name    = root_valid ? KEY_PORT_W'(root_name) : '0;
      res_surname = root_valid ? KEY_PORT_W'(root_surname) : '0;
      res_tag     = root_valid ? root_tag : '0;
   end

   // result queue control
   assign out_full  = (ocnt_ff == CNT_W'(QUEUE_DEPTH));
   assign rsp_empty = (ocnt_ff == '0);
   assign out_pop   = rsp_pop && !rsp_empty;

   always_comb begin
      owr_ptr_in = out_push ? owr_ptr_ff + PTR_W'(1) : owr_ptr_ff;
      ord_ptr_in = out_pop ? ord_ptr_ff + PTR_W'(1) : ord_ptr_ff;
      ocnt_in    = ocnt_ff;
      if (out_push && !out_pop) begin
         ocnt_in = ocnt_ff + CNT_W'(1);
      end else if (!out_push && out_pop) begin
         ocnt_in = ocnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         owr_ptr_ff <= '0;
         ord_ptr_ff <= '0;
         ocnt_ff    <= '0;
      end else begin
         owr_ptr_ff <= owr_ptr_in;
         ord_ptr_ff <= ord_ptr_in;
         ocnt_ff    <= ocnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_push) begin
         oq_kind_ff[owr_ptr_ff]    <= res_kind;
         oq_lane_ff[owr_ptr_ff]    <= res_lane;
         oq_name_ff[owr_ptr_ff]    <= res_name;
         oq_surname_ff[owr_ptr_ff] <= res_surname;
         oq_tag_ff[owr_ptr_ff]     <= res_tag;
      end
   end

   assign rsp_result_kind = oq_kind_ff[ord_ptr_ff];
   assign rsp_from_lane   = oq_lane_ff[ord_ptr_ff];
   assign rsp_out_name    = oq_name_ff[ord_ptr_ff];
   assign rsp_out_surname = oq_surname_ff[ord_ptr_ff];
   assign rsp_out_tag     = oq_tag_ff[ord_ptr_ff];

   // a lane never holds a head while it waits for one
   a_valid_not_waiting: assert property (@(posedge clock) disable iff (reset)
      (valid_ff & waiting_ff) == '0)
      else $error("lane both valid and waiting");

   // emitting only while the group is open and no lane in use waits
   a_emit_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (group_ff && ((waiting_ff & fan_mask) == '0)))
      else $error("emit state entered with a lane still waiting");

   // the emitted lane turns into a waiting lane
   a_emit_refill: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && !out_full && root_valid) |=>
      (waiting_ff[$past(root_lane)] && !valid_ff[$past(root_lane)]))
      else $error("emitted lane not marked for refill");

endmodule

/* src/kway_record_merge.sv */
// top level of the k-way record merge
//
// K-way merge of sorted runs. Request beats (start group, record for a lane,
// lane exhausted) enter a short command queue; the merge engine keeps one
// head per lane and, once no lane in use is waiting, returns the smallest
// head (name key, then surname key, lower lane on a tie) or a group-done
// beat when every lane is closed. Each beat is applied as it is popped; once
// no lane in use waits, the sequencer waits while the minimum passes the
// registered compare tree, with a register per tree level, and emits the
// result when the result queue has room; the next refill depends on it.
// ways_in_use (csr_wdata) sets the fan-in; 0 acts as 1, values above
// MAX_WAYS act as MAX_WAYS. Write it only while the block is idle.
module kway_record_merge #(
   parameter int MAX_WAYS  = kwrm_pkg::MAX_WAYS_DEF,
   parameter int KEY_BYTES = kwrm_pkg::KEY_BYTES_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_push,
   output logic                               req_full,
   input  logic [kwrm_pkg::TYPE_W-1:0]        req_type,
   input  logic [kwrm_pkg::LANE_W-1:0]        req_lane,
   input  logic [kwrm_pkg::KEY_PORT_W-1:0]    req_name_key,
   input  logic [kwrm_pkg::KEY_PORT_W-1:0]    req_surname_key,
   input  logic [kwrm_pkg::TAG_W-1:0]         req_record_tag,
   output logic                               rsp_empty,
   input  logic                               rsp_pop,
   output logic                               rsp_result_kind,
   output logic [kwrm_pkg::LANE_W-1:0]        rsp_from_lane,
   output logic [kwrm_pkg::KEY_PORT_W-1:0]    rsp_out_name,
   output logic [kwrm_pkg::KEY_PORT_W-1:0]    rsp_out_surname,
   output logic [kwrm_pkg::TAG_W-1:0]         rsp_out_tag,
   input  logic                               csr_write,
   input  logic [kwrm_pkg::CSR_W-1:0]         csr_wdata
);
   import kwrm_pkg::*;

   localparam int KEY_W = KEY_BYTES * 8;
   localparam int FAN_W = $clog2(MAX_WAYS + 1);
   localparam int CMP_W = (FAN_W > CSR_W) ? FAN_W : CSR_W;

   logic [CSR_W-1:0]  ways_ff, ways_in;
   logic [CMP_W-1:0]  ways_ext;
   logic [CMP_W-1:0]  fan_ext;
   logic [FAN_W-1:0]  fan_in;

   cmd_ctl_type       cmd_ctl;
   logic [KEY_W-1:0]  cmd_name;
   logic [KEY_W-1:0]  cmd_surname;
   logic [TAG_W-1:0]  cmd_tag;
   logic              cmd_avail;
   logic              cmd_pop;

   // fan-in register
   assign ways_in = csr_write ? csr_wdata : ways_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ways_ff <= CSR_RESET;
      end else begin
         ways_ff <= ways_in;
      end
   end

   // clamp the fan-in to one through MAX_WAYS
   always_comb begin
      ways_ext = CMP_W'(ways_ff);
      if (ways_ext == '0) begin
         fan_ext = CMP_W'(1);
      end else if (ways_ext > CMP_W'(MAX_WAYS)) begin
         fan_ext = CMP_W'(MAX_WAYS);
      end else begin
         fan_ext = ways_ext;
      end
      fan_in = FAN_W'(fan_ext);
   end

   kwrm_front #(
      .MAX_WAYS  (MAX_WAYS),
      .KEY_BYTES (KEY_BYTES)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_type        (req_type),
      .req_lane        (req_lane),
      .req_name_key    (req_name_key),
      .req_surname_key (req_surname_key),
      .req_record_tag  (req_record_tag),
      .fan_in          (fan_in),
      .cmd_ctl         (cmd_ctl),
      .cmd_name        (cmd_name),
      .cmd_surname     (cmd_surname),
      .cmd_tag         (cmd_tag),
      .cmd_avail       (cmd_avail),
      .cmd_pop         (cmd_pop)
   );

   kwrm_back #(
      .MAX_WAYS  (MAX_WAYS),
      .KEY_BYTES (KEY_BYTES)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .fan_in          (fan_in),
      .cmd_ctl         (cmd_ctl),
      .cmd_name        (cmd_name),
      .cmd_surname     (cmd_surname),
      .cmd_tag         (cmd_tag),
      .cmd_avail       (cmd_avail),
      .cmd_pop         (cmd_pop),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_result_kind (rsp_result_kind),
      .rsp_from_lane   (rsp_from_lane),
      .rsp_out_name    (rsp_out_name),
      .rsp_out_surname (rsp_out_surname),
      .rsp_out_tag     (rsp_out_tag)
   );

endmodule
